>>> hdl/sft_pkg.sv
package sft_pkg;

    localparam int CMD_W   = 3;
    localparam int IDX_W   = 3;
    localparam int DLY_W   = 16;
    localparam int KIND_W  = 2;
    localparam int MASK_W  = 8;

    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SETDELAY = 3'd5;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONE_SHOT = 2'd1;

    localparam logic [6:0] MS_LAST    = 7'd99;
    localparam logic [3:0] UNIT_LAST  = 4'd9;
    localparam logic [3:0] TENTH_LAST = 4'd9;
    localparam logic [2:0] SEC_LAST   = 3'd4;
    localparam logic [1:0] FIVE_LAST  = 2'd1;

    typedef struct packed {
        logic e10ms;
        logic e100ms;
        logic e1s;
        logic e5s;
        logic e10s;
    } t_events;

    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [DLY_W-1:0]  dly;
        logic [KIND_W-1:0] kind;
        logic              notify;
        t_events           events;
        logic [MASK_W-1:0] mask;
    } t_tok;

endpackage

>>> hdl/sft_req_if.sv
interface sft_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [2:0]  timer_index;
    logic [15:0] delay_value;
    logic [1:0]  timer_mode;
    logic        notify_enable;

    modport source (output valid, command, timer_index, delay_value, timer_mode,
                    notify_enable, input ready);
    modport sink (input valid, command, timer_index, delay_value, timer_mode,
                  notify_enable, output ready);
endinterface

>>> hdl/sft_rsp_if.sv
interface sft_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] fired_mask;
    logic       event_10ms;
    logic       event_100ms;
    logic       event_1s;
    logic       event_5s;
    logic       event_10s;

    modport source (output valid, fired_mask, event_10ms, event_100ms, event_1s,
                    event_5s, event_10s, input ready);
    modport sink (input valid, fired_mask, event_10ms, event_100ms, event_1s,
                  event_5s, event_10s, output ready);
endinterface

>>> hdl/software_timer_bank_core.sv
// channel  dir  modport        payload
// i_req    in   sft_req_if     command, timer_index, delay_value, timer_mode, notify_enable
// o_rsp    out  sft_rsp_if     fired_mask, event_10ms .. event_10s
//
// Each request walks the timer cells one per cycle, from the first cell to the last.
// The cell chain holds one request at a time; the divider counters update on each accepted tick.
// A finished response parks in a hold register if o_rsp is stalled; i_req waits for it.
// Synchronous active-low reset clears all timers and dividers.
module software_timer_bank_core
    import sft_pkg::*;
#(
    parameter int NUM_TIMERS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sft_req_if.sink   i_req,
    sft_rsp_if.source o_rsp
);

    t_tok    w_tok [NUM_TIMERS+1];
    t_events w_evt;
    logic    [NUM_TIMERS-1:0] w_busy_vec;
    logic    w_busy;
    logic    w_accept;
    logic    w_take;
    logic    w_done;

    logic    r_out_valid;
    t_tok    r_out;
    logic    r_hold_valid;
    t_tok    r_hold;

    assign i_req.ready = !w_busy && !r_hold_valid;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_take      = r_out_valid && o_rsp.ready;
    assign w_done      = w_tok[NUM_TIMERS].valid;

    sft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_accept && i_req.command == CMD_TICK),
        .o_evt   (w_evt)
    );

    always_comb begin
        w_tok[0].valid  = w_accept;
        w_tok[0].cmd    = i_req.command;
        w_tok[0].idx    = i_req.timer_index;
        w_tok[0].dly    = i_req.delay_value;
        w_tok[0].kind   = i_req.timer_mode;
        w_tok[0].notify = i_req.notify_enable;
        w_tok[0].events = w_evt;
        w_tok[0].mask   = '0;
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        sft_cell #(.INDEX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_busy_vec[g] = w_tok[g+1].valid;
    end

    assign w_busy = |w_busy_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (w_done) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_hold_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid  <= r_hold_valid;
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_tok[NUM_TIMERS];
            end else begin
                r_hold <= w_tok[NUM_TIMERS];
            end
        end else if (w_take && r_hold_valid) begin
            r_out <= r_hold;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.fired_mask  = r_out.mask;
    assign o_rsp.event_10ms  = r_out.events.e10ms;
    assign o_rsp.event_100ms = r_out.events.e100ms;
    assign o_rsp.event_1s    = r_out.events.e1s;
    assign o_rsp.event_5s    = r_out.events.e5s;
    assign o_rsp.event_10s   = r_out.events.e10s;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_busy_vec))
        else $error("more than one request in the cell chain");

    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("hold register full while output empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_tok[1].valid)
        else $error("accepted request did not enter first cell");

    a_done_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_hold_valid)
        else $error("request finished while hold register full");

endmodule

>>> hdl/sft_div.sv
module sft_div
    import sft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick,
    output t_events o_evt
);

    logic [6:0] r_ms, n_ms;
    logic [3:0] r_unit, n_unit;
    logic [3:0] r_tenth, n_tenth;
    logic [2:0] r_sec, n_sec;
    logic [1:0] r_five, n_five;

    always_comb begin
        n_ms    = r_ms;
        n_unit  = r_unit;
        n_tenth = r_tenth;
        n_sec   = r_sec;
        n_five  = r_five;
        o_evt   = '0;
        if (i_tick) begin
            if (r_ms == MS_LAST) begin
                n_ms         = '0;
                n_unit       = '0;
                o_evt.e100ms = 1'b1;
                if (r_tenth == TENTH_LAST) begin
                    n_tenth   = '0;
                    o_evt.e1s = 1'b1;
                    if (r_sec == SEC_LAST) begin
                        n_sec     = '0;
                        o_evt.e5s = 1'b1;
                        if (r_five == FIVE_LAST) begin
                            n_five     = '0;
                            o_evt.e10s = 1'b1;
                        end else begin
                            n_five = r_five + 2'd1;
                        end
                    end else begin
                        n_sec = r_sec + 3'd1;
                    end
                end else begin
                    n_tenth = r_tenth + 4'd1;
                end
            end else begin
                n_ms = r_ms + 7'd1;
                if (r_unit == UNIT_LAST) begin
                    n_unit      = '0;
                    o_evt.e10ms = 1'b1;
                end else begin
                    n_unit = r_unit + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms    <= '0;
            r_unit  <= '0;
            r_tenth <= '0;
            r_sec   <= '0;
            r_five  <= '0;
        end else begin
            r_ms    <= n_ms;
            r_unit  <= n_unit;
            r_tenth <= n_tenth;
            r_sec   <= n_sec;
            r_five  <= n_five;
        end
    end

endmodule

>>> hdl/sft_cell.sv
module sft_cell
    import sft_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic              r_en, n_en;
    logic [DLY_W-1:0]  r_dly, n_dly;
    logic [DLY_W-1:0]  r_cnt, n_cnt;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_notify, n_notify;
    t_tok              r_tok, n_tok;

    logic [DLY_W-1:0]  w_inc;
    logic              w_hit;
    logic              w_fire;

    assign w_inc = r_cnt + 16'd1;
    assign w_hit = (INDEX < 8) && (i_tok.idx == IDX_W'(INDEX));

    always_comb begin
        n_en     = r_en;
        n_dly    = r_dly;
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_notify = r_notify;
        w_fire   = 1'b0;
        n_tok    = i_tok;
        if (i_tok.valid) begin
            if (i_tok.cmd == CMD_TICK) begin
                if (r_en) begin
                    n_cnt = w_inc;
                    if (w_inc == r_dly && r_kind != KIND_NONE) begin
                        n_cnt  = '0;
                        w_fire = r_notify;
                        if (r_kind == KIND_ONE_SHOT) begin
                            n_en     = 1'b0;
                            n_dly    = '0;
                            n_kind   = KIND_NONE;
                            n_notify = 1'b0;
                        end
                    end
                end
            end else if (w_hit) begin
                unique case (i_tok.cmd)
                    CMD_START: begin
                        n_en     = 1'b1;
                        n_dly    = i_tok.dly;
                        n_cnt    = '0;
                        n_kind   = i_tok.kind;
                        n_notify = i_tok.notify;
                    end
                    CMD_PAUSE: begin
                        n_en = 1'b0;
                    end
                    CMD_STOP: begin
                        n_en     = 1'b0;
                        n_dly    = '0;
                        n_cnt    = '0;
                        n_kind   = KIND_NONE;
                        n_notify = 1'b0;
                    end
                    CMD_RESTART: begin
                        n_cnt = '0;
                    end
                    CMD_SETDELAY: begin
                        n_cnt = '0;
                        n_dly = i_tok.dly;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (w_fire) begin
            n_tok.mask = i_tok.mask | (MASK_W'(1) << INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_dly    <= '0;
            r_cnt    <= '0;
            r_kind   <= KIND_NONE;
            r_notify <= 1'b0;
            r_tok    <= '0;
        end else begin
            r_en     <= n_en;
            r_dly    <= n_dly;
            r_cnt    <= n_cnt;
            r_kind   <= n_kind;
            r_notify <= n_notify;
            r_tok    <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sft_pkg::*;

    localparam int NUM_TIMERS = 8;

    localparam logic [CMD_W-1:0]  CMD_SPARE_6   = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_7   = 3'd7;
    localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CODE3    = 2'd3;

    localparam int IDLE_PCT      = 8;
    localparam int RANDOM_ITEMS  = 560;
    localparam int SOAK_ITEMS    = 120;
    localparam int CALM_FIRST    = 250;
    localparam int CALM_LAST     = 450;
    localparam int DRAIN_CYCLES  = 8 * (NUM_TIMERS + 2);
    localparam int CYCLES_PER_RQ = 40;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [DLY_W-1:0]  dly;
        logic [KIND_W-1:0] mode;
        logic              notify;
        bit                hold;
    } t_timer_req;

    typedef struct packed {
        logic [MASK_W-1:0] fired;
        t_events           ev;
    } t_timer_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sft_req_if req_bus();
    sft_rsp_if rsp_bus();

    software_timer_bank_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    logic       req_valid = 1'b0;
    t_timer_req req_word  = '{default: '0};
    logic       rsp_ready = 1'b0;

    assign req_bus.valid         = req_valid;
    assign req_bus.command       = req_word.cmd;
    assign req_bus.timer_index   = req_word.idx;
    assign req_bus.delay_value   = req_word.dly;
    assign req_bus.timer_mode    = req_word.mode;
    assign req_bus.notify_enable = req_word.notify;
    assign rsp_bus.ready         = rsp_ready;

    t_timer_req cmd_backlog[$];
    t_timer_rsp predicted_rsp[$];

    int req_count     = 0;
    int rsp_count     = 0;
    int total_items   = 0;
    int mismatch_count = 0;
    int tick_total    = 0;
    int fired_total   = 0;
    int hits_100ms    = 0;
    int hits_1s       = 0;
    int hits_10s      = 0;

    // timer bank state as seen by the predictor
    bit              slot_en[NUM_TIMERS];
    bit [DLY_W-1:0]  slot_delay[NUM_TIMERS];
    bit [DLY_W-1:0]  slot_count[NUM_TIMERS];
    bit [KIND_W-1:0] slot_kind[NUM_TIMERS];
    bit              slot_notify[NUM_TIMERS];
    bit [6:0]        ms_cnt;
    bit [3:0]        tenth_cnt;
    bit [2:0]        sec_cnt;
    bit [1:0]        five_cnt;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_slot(int t);
        slot_en[t]     = 1'b0;
        slot_delay[t]  = '0;
        slot_count[t]  = '0;
        slot_kind[t]   = KIND_NONE;
        slot_notify[t] = 1'b0;
    endfunction

    function automatic t_timer_rsp advance_timer_bank(t_timer_req r);
        t_timer_rsp rsp;
        rsp = '0;
        if (r.cmd == CMD_TICK) begin
            tick_total++;
            ms_cnt = ms_cnt + 7'd1;
            if (ms_cnt > MS_LAST) begin
                ms_cnt = '0;
                rsp.ev.e100ms = 1'b1;
                tenth_cnt = tenth_cnt + 4'd1;
                if (tenth_cnt > TENTH_LAST) begin
                    tenth_cnt = '0;
                    sec_cnt = sec_cnt + 3'd1;
                    rsp.ev.e1s = 1'b1;
                end
                if (sec_cnt > SEC_LAST) begin
                    sec_cnt = '0;
                    five_cnt = five_cnt + 2'd1;
                    rsp.ev.e5s = 1'b1;
                end
                if (five_cnt > FIVE_LAST) begin
                    five_cnt = '0;
                    rsp.ev.e10s = 1'b1;
                end
            end else if (ms_cnt % (UNIT_LAST + 7'd1) == 0) begin
                rsp.ev.e10ms = 1'b1;
            end
            for (int t = 0; t < NUM_TIMERS; t++) begin
                if (slot_en[t]) begin
                    slot_count[t] = slot_count[t] + 16'd1;
                    if (slot_count[t] == slot_delay[t] && slot_kind[t] != KIND_NONE) begin
                        slot_count[t] = '0;
                        if (slot_notify[t] && t < MASK_W) rsp.fired[t] = 1'b1;
                        if (slot_kind[t] == KIND_ONE_SHOT) clear_slot(t);
                    end
                end
            end
        end else if (r.idx < NUM_TIMERS) begin
            case (r.cmd)
                CMD_START: begin
                    slot_en[r.idx]     = 1'b1;
                    slot_delay[r.idx]  = r.dly;
                    slot_count[r.idx]  = '0;
                    slot_kind[r.idx]   = r.mode;
                    slot_notify[r.idx] = r.notify;
                end
                CMD_PAUSE:   slot_en[r.idx] = 1'b0;
                CMD_STOP:    clear_slot(r.idx);
                CMD_RESTART: slot_count[r.idx] = '0;
                CMD_SETDELAY: begin
                    slot_count[r.idx] = '0;
                    slot_delay[r.idx] = r.dly;
                end
                default: ;
            endcase
        end
        return rsp;
    endfunction

    function automatic void push_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                     logic [DLY_W-1:0] dly, logic [KIND_W-1:0] mode,
                                     logic notify, bit hold = 1'b0);
        t_timer_req r;
        r.cmd    = cmd;
        r.idx    = idx;
        r.dly    = dly;
        r.mode   = mode;
        r.notify = notify;
        r.hold   = hold;
        cmd_backlog.push_back(r);
    endfunction

    // ticks carry random junk in the fields they ignore
    function automatic void push_tick();
        push_req(CMD_TICK, IDX_W'($urandom_range((1 << IDX_W) - 1)), DLY_W'($urandom),
                 KIND_W'($urandom_range((1 << KIND_W) - 1)), 1'($urandom_range(1)));
    endfunction

    function automatic logic [DLY_W-1:0] pick_delay();
        case ($urandom_range(15))
            0, 1:    return DLY_W'($urandom);
            2:       return '0;
            default: return DLY_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_mode();
        return KIND_W'($urandom_range((1 << KIND_W) - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_timer_cmd();
        return CMD_W'($urandom_range(CMD_START, CMD_SETDELAY));
    endfunction

    function automatic bit idle_now(int done);
        if (done >= CALM_FIRST && done < CALM_LAST) return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic void check_field(string name, logic [MASK_W-1:0] want,
                                        logic [MASK_W-1:0] got);
        if (got !== want) begin
            note_mismatch($sformatf("response %0d %s: expected 0x%0h, got 0x%0h",
                                    rsp_count, name, want, got));
        end
    endfunction

    always @(posedge i_clk) begin : drive_requests
        bit         taken;
        t_timer_req next_req;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            taken = req_valid && req_bus.ready;
            if (taken) begin
                predicted_rsp.push_back(advance_timer_bank(req_word));
                req_count <= req_count + 1;
            end
            if (!req_valid || taken) begin
                if (cmd_backlog.size() != 0 && !idle_now(req_count)
                    && !(cmd_backlog[0].hold && req_count + int'(taken) != rsp_count)) begin
                    next_req = cmd_backlog.pop_front();
                    req_word  <= next_req;
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_responses
        t_timer_rsp want;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_ready) begin
                rsp_count <= rsp_count + 1;
                fired_total += $countones(rsp_bus.fired_mask);
                hits_100ms  += int'(rsp_bus.event_100ms === 1'b1);
                hits_1s     += int'(rsp_bus.event_1s === 1'b1);
                hits_10s    += int'(rsp_bus.event_10s === 1'b1);
                if (predicted_rsp.size() == 0) begin
                    note_mismatch($sformatf("response %0d arrived with no request outstanding",
                                            rsp_count));
                end else begin
                    want = predicted_rsp.pop_front();
                    check_field("fired_mask", want.fired, rsp_bus.fired_mask);
                    check_field("event_10ms", MASK_W'(want.ev.e10ms), MASK_W'(rsp_bus.event_10ms));
                    check_field("event_100ms", MASK_W'(want.ev.e100ms),
                                MASK_W'(rsp_bus.event_100ms));
                    check_field("event_1s", MASK_W'(want.ev.e1s), MASK_W'(rsp_bus.event_1s));
                    check_field("event_5s", MASK_W'(want.ev.e5s), MASK_W'(rsp_bus.event_5s));
                    check_field("event_10s", MASK_W'(want.ev.e10s), MASK_W'(rsp_bus.event_10s));
                end
            end
            rsp_ready <= !idle_now(rsp_count);
        end
    end

    initial begin : run_test
        int     n;
        int     slot;
        longint cycle_count;
        longint cycle_limit;

        // directed: every command, mode and field extreme
        push_tick();
        push_req(CMD_START, IDX_W'(0), 16'd3, KIND_PERIODIC, 1'b1);
        push_req(CMD_START, IDX_W'(1), 16'd1, KIND_ONE_SHOT, 1'b1);
        push_req(CMD_START, IDX_W'(2), 16'd2, KIND_NONE, 1'b1);
        push_req(CMD_START, IDX_W'(3), '1, KIND_CODE3, 1'b0);
        push_req(CMD_START, IDX_W'(4), 16'd2, KIND_CODE3, 1'b1);
        repeat (3) push_tick();
        push_req(CMD_PAUSE, IDX_W'(0), '1, '1, 1'b1);
        push_tick();
        push_req(CMD_RESTART, IDX_W'(4), '0, '0, 1'b0);
        push_req(CMD_SETDELAY, IDX_W'(0), 16'd1, '0, 1'b0);
        push_tick();
        push_req(CMD_START, IDX_W'(0), 16'd1, KIND_PERIODIC, 1'b1);
        push_req(CMD_STOP, IDX_W'(3), '0, '0, 1'b0);
        push_req(CMD_SPARE_6, IDX_W'(5), '1, '1, 1'b1);
        push_req(CMD_SPARE_7, IDX_W'(0), '0, '0, 1'b0);
        repeat (2) push_tick();
        push_req(CMD_PAUSE, IDX_W'(NUM_TIMERS - 1), '0, '0, 1'b0);
        push_req(CMD_SETDELAY, IDX_W'(NUM_TIMERS - 1), '1, '0, 1'b0);
        push_req(CMD_RESTART, IDX_W'(NUM_TIMERS - 1), '0, '0, 1'b0);
        push_req(CMD_STOP, IDX_W'(0), '1, '1, 1'b1);

        // random: mostly start-then-tick bursts, some raw noise
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if ($urandom_range(3) != 0) begin
                slot = $urandom_range(NUM_TIMERS - 1);
                push_req(CMD_START, IDX_W'(slot), pick_delay(), pick_mode(),
                         1'($urandom_range(4) != 0), n == 0);
                n++;
                repeat ($urandom_range(1, 25)) begin
                    if ($urandom_range(9) == 0) begin
                        push_req(pick_timer_cmd(), IDX_W'($urandom_range(NUM_TIMERS - 1)),
                                 pick_delay(), pick_mode(), 1'($urandom_range(1)));
                    end else begin
                        push_tick();
                    end
                    n++;
                end
            end else begin
                push_req(CMD_W'($urandom_range((1 << CMD_W) - 1)),
                         IDX_W'($urandom_range((1 << IDX_W) - 1)), DLY_W'($urandom),
                         pick_mode(), 1'($urandom_range(1)));
                n++;
            end
        end

        // closing tick run with zero-delay timers counting
        push_req(CMD_START, IDX_W'(NUM_TIMERS - 1), '0, KIND_PERIODIC, 1'b1, 1'b1);
        push_req(CMD_START, IDX_W'(NUM_TIMERS - 2), '0, KIND_ONE_SHOT, 1'b1);
        repeat (SOAK_ITEMS) begin
            if ($urandom_range(99) == 0) begin
                push_req(pick_timer_cmd(), IDX_W'($urandom_range(NUM_TIMERS - 3)),
                         pick_delay(), pick_mode(), 1'($urandom_range(1)));
            end else begin
                push_tick();
            end
        end

        total_items = cmd_backlog.size();
        cycle_limit = longint'(total_items) * CYCLES_PER_RQ + 10000;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cycle_count = 0;
        while (rsp_count != total_items && cycle_count < cycle_limit) begin
            @(posedge i_clk);
            cycle_count++;
        end

        if (cycle_count >= cycle_limit) begin
            $display("timeout after %0d cycles: %0d of %0d responses seen",
                     cycle_count, rsp_count, total_items);
            $display("end of test: mismatches");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            $display("%0d requests (%0d ticks), %0d timer expiries reported",
                     total_items, tick_total, fired_total);
            $display("divider events: %0d at 100 ms, %0d at 1 s, %0d at 10 s; %0d mismatches",
                     hits_100ms, hits_1s, hits_10s, mismatch_count);
            if (mismatch_count == 0 && predicted_rsp.size() == 0) begin
                $display("end of test: clean");
            end else begin
                $display("end of test: mismatches");
            end
        end
        $finish;
    end

endmodule

>>> files.f
hdl/sft_pkg.sv
hdl/sft_req_if.sv
hdl/sft_rsp_if.sv
hdl/sft_div.sv
hdl/sft_cell.sv
hdl/software_timer_bank_core.sv
tb/testbench.sv
